// ===== rtl/dvu_pkg.sv =====
package dvu_pkg;

	// Operand width of the datapath; the port fields are always FIELD_WIDTH wide
	localparam int DATA_WIDTH  = 64;
	localparam int FIELD_WIDTH = 64;
	localparam int STEPS       = DATA_WIDTH;

	typedef logic [DATA_WIDTH-1:0]  word_t;
	typedef logic [FIELD_WIDTH-1:0] field_t;

	typedef struct packed {
		logic valid;
		logic negate;
		logic dbz;
	} dvu_ctrl_t;

	typedef struct packed {
		dvu_ctrl_t ctrl;
		word_t     rem;
		word_t     quo;
		word_t     den;
	} dvu_stage_t;

endpackage

// ===== rtl/dvu_req_if.sv =====
interface dvu_req_if import dvu_pkg::*;;
	logic   valid;
	logic   ready;
	field_t dividend;
	field_t divisor;
	logic   mode;

	modport source (output valid, output dividend, output divisor, output mode, input ready);
	modport sink (input valid, input dividend, input divisor, input mode, output ready);
endinterface

// ===== rtl/dvu_rsp_if.sv =====
interface dvu_rsp_if import dvu_pkg::*;;
	logic   valid;
	logic   ready;
	field_t quotient;
	logic   divide_by_zero;

	modport source (output valid, output quotient, output divide_by_zero, input ready);
	modport sink (input valid, input quotient, input divide_by_zero, output ready);
endinterface

// ===== rtl/int64_restoring_divider_unit.sv =====
// Pipelined radix-2 restoring divider, 64-bit dividend and divisor.
//
// req channel: dividend, divisor and mode (0 unsigned, 1 signed, truncating
// toward zero). rsp channel: quotient and divide_by_zero. A transfer happens
// on a rising clk edge with valid and ready both high.
//
// Pipeline: one operand stage loaded at the request transfer edge, 64 restoring
// stages and one output register, which drives rsp.valid. Throughput: one
// division per cycle unless a receiver stall freezes the pipeline. The rate is
// set by the 64 restoring stages, each holding one 64-bit subtract and compare.
//
// A zero divisor gives quotient zero with divide_by_zero set. In signed mode
// the most negative value divided by minus one wraps to itself.
//
// Reset (arst_n low) clears every valid bit; rsp.valid goes low and req.ready
// goes high. When the receiver stalls, the output register holds its result
// and one further result lands in a skid entry; req.ready then drops and the
// whole pipeline freezes until the held result is taken.
module int64_restoring_divider_unit import dvu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dvu_req_if.sink    req,
	dvu_rsp_if.source  rsp
);

	logic       en;
	dvu_stage_t pipe [0:STEPS];

	assign req.ready = en;

	dvu_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (req.valid),
		.dividend (req.dividend),
		.divisor  (req.divisor),
		.mode     (req.mode),
		.lane     (pipe[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		dvu_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.prev   (pipe[i]),
			.next   (pipe[i+1])
		);
	end

	dvu_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.last   (pipe[STEPS]),
		.en     (en),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/dvu_prep.sv =====
module dvu_prep import dvu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       valid,
	input  field_t     dividend,
	input  field_t     divisor,
	input  logic       mode,
	output dvu_stage_t lane
);

	word_t     a;
	word_t     b;
	logic      a_neg;
	logic      b_neg;
	word_t     a_mag;
	word_t     b_mag;
	logic      valid_s1;
	dvu_ctrl_t ctrl_s1;
	word_t     quo_s1;
	word_t     den_s1;

	always_comb begin
		a     = dividend[DATA_WIDTH-1:0];
		b     = divisor[DATA_WIDTH-1:0];
		a_neg = mode & a[DATA_WIDTH-1];
		b_neg = mode & b[DATA_WIDTH-1];
		a_mag = a_neg ? (~a + word_t'(1)) : a;
		b_mag = b_neg ? (~b + word_t'(1)) : b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1.valid  <= 1'b0;
			ctrl_s1.negate <= a_neg ^ b_neg;
			ctrl_s1.dbz    <= (b == '0);
			quo_s1         <= a_mag;
			den_s1         <= b_mag;
		end
	end

	always_comb begin
		lane            = '0;
		lane.ctrl       = ctrl_s1;
		lane.ctrl.valid = valid_s1;
		lane.rem        = '0;
		lane.quo        = quo_s1;
		lane.den        = den_s1;
	end

endmodule

// ===== rtl/dvu_step.sv =====
module dvu_step import dvu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  dvu_stage_t prev,
	output dvu_stage_t next
);

	logic [DATA_WIDTH:0] shifted;
	logic [DATA_WIDTH:0] diff;
	logic                take;
	word_t               rem_d;
	word_t               quo_d;
	logic                valid_s1;
	dvu_stage_t          lane_s1;

	// shifted stays below twice the divisor, so bit DATA_WIDTH of diff is the borrow
	always_comb begin
		shifted = {prev.rem, prev.quo[DATA_WIDTH-1]};
		diff    = shifted - {1'b0, prev.den};
		take    = ~diff[DATA_WIDTH];
		rem_d   = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
		quo_d   = {prev.quo[DATA_WIDTH-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= prev.ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1.ctrl <= prev.ctrl;
			lane_s1.rem  <= rem_d;
			lane_s1.quo  <= quo_d;
			lane_s1.den  <= prev.den;
		end
	end

	always_comb begin
		next            = lane_s1;
		next.ctrl.valid = valid_s1;
	end

endmodule

// ===== rtl/dvu_post.sv =====
module dvu_post import dvu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dvu_stage_t       last,
	output logic             en,
	dvu_rsp_if.source        rsp
);

	logic  new_valid;
	word_t new_quo;
	logic  out_valid_q;
	word_t out_quo_q;
	logic  out_dbz_q;
	logic  skid_valid_q;
	word_t skid_quo_q;
	logic  skid_dbz_q;

	// freeze the pipeline while the skid entry is occupied
	assign en        = ~skid_valid_q;
	assign new_valid = last.ctrl.valid & en;

	always_comb begin
		if (last.ctrl.dbz) begin
			new_quo = '0;
		end else if (last.ctrl.negate) begin
			new_quo = ~last.quo + word_t'(1);
		end else begin
			new_quo = last.quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= new_valid;
			end
		end else if (new_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || rsp.ready) begin
			if (skid_valid_q) begin
				out_quo_q <= skid_quo_q;
				out_dbz_q <= skid_dbz_q;
			end else begin
				out_quo_q <= new_quo;
				out_dbz_q <= last.ctrl.dbz;
			end
		end else if (new_valid) begin
			skid_quo_q <= new_quo;
			skid_dbz_q <= last.ctrl.dbz;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.quotient       = field_t'(out_quo_q);
	assign rsp.divide_by_zero = out_dbz_q;

endmodule

// ===== rtl/dvu_checker.sv =====
module dvu_checker import dvu_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   req_ready,
	input logic   rsp_valid,
	input logic   rsp_ready,
	input field_t rsp_quotient,
	input logic   rsp_divide_by_zero
);

	// a held result keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient)
			&& $stable(rsp_divide_by_zero))
		else $error("rsp payload changed while stalled");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_divide_by_zero |-> rsp_quotient == '0)
		else $error("divide by zero with non-zero quotient");

	// request side only backs off after the output was stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> $past(rsp_valid && !rsp_ready))
		else $error("req.ready low without an output stall");

	// a freed skid entry reopens the request side
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready && rsp_ready |=> req_ready)
		else $error("req.ready stayed low after the held result was taken");

endmodule

bind int64_restoring_divider_unit dvu_checker u_dvu_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_quotient       (rsp.quotient),
	.rsp_divide_by_zero (rsp.divide_by_zero)
);
